// ===== design/sflr_pkg.sv =====
// shared types and constants for the slot free-list rebuilder
package sflr_pkg;

   localparam int OPC_W      = 3;
   localparam int IDX_W      = 12;
   localparam int TYPE_W     = 8;
   localparam int HEAD_W     = 13;
   localparam int LAST_W     = 12;
   localparam int COUNT_W    = 13;
   localparam int LINK_W     = 13;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 72;

   typedef enum logic [OPC_W-1:0] {
      OP_CLEAR    = 3'd0,
      OP_WRITE    = 3'd1,
      OP_SET_LAST = 3'd2,
      OP_REBUILD  = 3'd3,
      OP_RECOUNT  = 3'd4,
      OP_READ     = 3'd5
   } opcode_type;

   typedef struct packed {
      logic rd_en;
      logic type_we;
      logic link_we;
      logic clear_we;
   } slot_ctl_type;

   typedef struct packed {
      logic rd_en;
      logic clear_we;
      logic inc_en;
   } hist_ctl_type;

endpackage

// ===== design/slot_free_list_rebuilder.sv =====
// slot free-list rebuilder top level: operation sequencer and result register
//
//   channel | ports                     | fields (lsb first)
//   --------+---------------------------+----------------------------------------------
//   request | req_tvalid/tready/tdata   | opcode, slot_index, type_value
//   result  | rsp_tvalid/tready/tdata   | free_head, last_active_out, total_used,
//           |                           | slot_type_out, slot_link_out, type_count_out
//
// write, set last active, read and unused codes: no walk or sweep, straight to the result
// clear: one memory entry swept per cycle
// rebuild: one slot type read per cycle, from slot 0 up to last active
// recount: count memory cleared, then every slot type counted
// after reset a clearing sweep over all slot and count entries runs with req_tready low
// a finished result waits in the output register while the next request is taken
module slot_free_list_rebuilder #(
   parameter int NUM_SLOTS = 4096,
   parameter int NUM_TYPES = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // opcode, slot_index, type_value, zero pad
   input  logic [sflr_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // free_head, last_active_out, total_used, slot_type_out, slot_link_out, type_count_out
   output logic [sflr_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int AW  = $clog2(NUM_SLOTS);
   localparam int LW  = AW + 1;
   localparam int TW  = $clog2(NUM_TYPES);
   localparam int SW  = (NUM_SLOTS > NUM_TYPES) ? NUM_SLOTS : NUM_TYPES;
   localparam int CW  = $clog2(SW);
   localparam int IW  = ((AW > sflr_pkg::IDX_W) ? AW : sflr_pkg::IDX_W) + 1;
   localparam int TCW = ((TW > sflr_pkg::TYPE_W) ? TW : sflr_pkg::TYPE_W) + 1;
   localparam int LAW = (AW > sflr_pkg::LAST_W) ? AW : sflr_pkg::LAST_W;
   localparam int HW  = (LW > sflr_pkg::HEAD_W) ? LW : sflr_pkg::HEAD_W;

   localparam int IDX_LO = sflr_pkg::OPC_W;
   localparam int TV_LO  = sflr_pkg::OPC_W + sflr_pkg::IDX_W;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_RB_WALK,
      ST_RB_END,
      ST_RC_CLR,
      ST_RC_WALK,
      ST_RESP
   } state_type;

   state_type                     state_ff;
   sflr_pkg::opcode_type          op_ff;
   logic                          idx_ok_ff;
   logic                          tv_ok_ff;
   logic                          silent_ff;
   logic [CW-1:0]                 cnt_ff;
   logic                          walk_done_ff;
   logic                          s1_valid_ff;
   logic [AW-1:0]                 s1_idx_ff;
   logic                          have_free_ff;
   logic [AW-1:0]                 last_free_ff;
   logic [AW-1:0]                 last_used_ff;
   logic signed [LW-1:0]          head_ff;
   logic [AW-1:0]                 last_active_ff;
   logic [sflr_pkg::COUNT_W-1:0]  total_ff;
   logic                          rsp_valid_ff;
   logic [sflr_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   sflr_pkg::opcode_type          opcode_in;
   logic [sflr_pkg::IDX_W-1:0]    idx_in;
   logic [sflr_pkg::TYPE_W-1:0]   tv_in;
   logic [IW-1:0]                 idx_wide;
   logic                          idx_ok;
   logic [AW-1:0]                 idx_addr;
   logic [TCW-1:0]                tv_wide;
   logic                          tv_ok;
   logic [TW-1:0]                 tv_addr;
   logic [TCW-1:0]                t_wide;
   logic [TW-1:0]                 t_addr;
   logic                          t_used;
   logic                          t_count;
   logic                          accept;
   logic                          issue;
   logic                          out_free;
   logic [AW-1:0]                 cnt_slot;
   logic [TW-1:0]                 cnt_type;
   logic                          cnt_in_slots;
   logic                          cnt_in_types;
   logic                          sweep_last;
   logic                          rb_last;
   logic                          rc_clr_last;
   logic                          rc_walk_last;
   logic signed [LW-1:0]          tail;

   sflr_pkg::slot_ctl_type        slot_ctl;
   logic [AW-1:0]                 slot_rd_addr;
   logic [AW-1:0]                 slot_wr_addr;
   logic signed [LW-1:0]          slot_link_data;
   logic [sflr_pkg::TYPE_W-1:0]   type_rd;
   logic signed [LW-1:0]          link_rd;

   sflr_pkg::hist_ctl_type        hist_ctl;
   logic [TW-1:0]                 hist_addr;
   logic [sflr_pkg::COUNT_W-1:0]  hist_rd;
   logic                          hist_busy;

   logic [sflr_pkg::TYPE_W-1:0]   resp_type;
   logic signed [HW-1:0]          link_wide;
   logic signed [HW-1:0]          head_wide;
   logic [LAW-1:0]                la_wide;
   logic [sflr_pkg::COUNT_W-1:0]  resp_count;
   logic [sflr_pkg::RSP_DATA_W-1:0] resp_data;

   assign opcode_in = sflr_pkg::opcode_type'(req_tdata[sflr_pkg::OPC_W-1:0]);
   assign idx_in    = req_tdata[TV_LO-1:IDX_LO];
   assign tv_in     = req_tdata[TV_LO+sflr_pkg::TYPE_W-1:TV_LO];

   assign idx_wide  = IW'(idx_in);
   assign idx_ok    = idx_wide < IW'(NUM_SLOTS);
   assign idx_addr  = idx_wide[AW-1:0];
   assign tv_wide   = TCW'(tv_in);
   assign tv_ok     = tv_wide < TCW'(NUM_TYPES);
   assign tv_addr   = tv_wide[TW-1:0];
   assign t_wide    = TCW'(type_rd);
   assign t_addr    = t_wide[TW-1:0];
   assign t_used    = s1_valid_ff && (type_rd != '0);
   assign t_count   = t_used && (t_wide < TCW'(NUM_TYPES));

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign issue      = !walk_done_ff && (state_ff == ST_RB_WALK || state_ff == ST_RC_WALK);

   assign cnt_slot     = cnt_ff[AW-1:0];
   assign cnt_type     = cnt_ff[TW-1:0];
   assign cnt_in_slots = (CW+1)'(cnt_ff) < (CW+1)'(NUM_SLOTS);
   assign cnt_in_types = (CW+1)'(cnt_ff) < (CW+1)'(NUM_TYPES);
   assign sweep_last   = cnt_ff == CW'(SW - 1);
   assign rb_last      = cnt_slot == last_active_ff;
   assign rc_clr_last  = cnt_ff == CW'(NUM_TYPES - 1);
   assign rc_walk_last = cnt_ff == CW'(NUM_SLOTS - 1);
   assign tail = (last_active_ff == AW'(NUM_SLOTS - 1)) ? '1 : LW'(last_active_ff) + LW'(1);

   always_comb begin
      slot_ctl       = '0;
      slot_rd_addr   = idx_addr;
      slot_wr_addr   = idx_addr;
      slot_link_data = LW'(s1_idx_ff);
      hist_ctl       = '0;
      hist_addr      = tv_addr;
      case (state_ff)
         ST_SWEEP: begin
            slot_ctl.clear_we = cnt_in_slots;
            slot_wr_addr      = cnt_slot;
            hist_ctl.clear_we = cnt_in_types;
            hist_addr         = cnt_type;
         end
         ST_IDLE: begin
            slot_ctl.rd_en   = accept && opcode_in == sflr_pkg::OP_READ && idx_ok;
            slot_ctl.type_we = accept && opcode_in == sflr_pkg::OP_WRITE && idx_ok;
            hist_ctl.rd_en   = accept && opcode_in == sflr_pkg::OP_READ && tv_ok;
         end
         ST_RB_WALK: begin
            slot_ctl.rd_en   = issue;
            slot_rd_addr     = cnt_slot;
            slot_ctl.link_we = s1_valid_ff && type_rd == '0 && have_free_ff;
            slot_wr_addr     = last_free_ff;
         end
         ST_RB_END: begin
            slot_ctl.link_we = have_free_ff;
            slot_wr_addr     = last_free_ff;
            slot_link_data   = tail;
         end
         ST_RC_CLR: begin
            hist_ctl.clear_we = 1'b1;
            hist_addr         = cnt_type;
         end
         ST_RC_WALK: begin
            slot_ctl.rd_en  = issue;
            slot_rd_addr    = cnt_slot;
            hist_ctl.inc_en = t_count;
         end
         default: begin
         end
      endcase
   end

   sflr_slot_table #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_slot_table (
      .clock        (clock),
      .ctl          (slot_ctl),
      .rd_addr      (slot_rd_addr),
      .wr_addr      (slot_wr_addr),
      .type_wr_data (tv_in),
      .link_wr_data (slot_link_data),
      .type_rd_ff   (type_rd),
      .link_rd_ff   (link_rd)
   );

   sflr_hist #(
      .NUM_TYPES (NUM_TYPES)
   ) u_hist (
      .clock    (clock),
      .reset    (reset),
      .ctl      (hist_ctl),
      .addr     (hist_addr),
      .inc_addr (t_addr),
      .rd_ff    (hist_rd),
      .busy     (hist_busy)
   );

   always_comb begin
      head_wide  = HW'(head_ff);
      la_wide    = LAW'(last_active_ff);
      resp_type  = '0;
      link_wide  = '0;
      resp_count = '0;
      if (op_ff == sflr_pkg::OP_READ) begin
         resp_type  = idx_ok_ff ? type_rd : '0;
         link_wide  = idx_ok_ff ? HW'(link_rd) : '1;
         resp_count = tv_ok_ff ? hist_rd : '0;
      end
      resp_data = {resp_count,
                   link_wide[sflr_pkg::LINK_W-1:0],
                   resp_type,
                   total_ff,
                   la_wide[sflr_pkg::LAST_W-1:0],
                   head_wide[sflr_pkg::HEAD_W-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SWEEP;
         silent_ff      <= 1'b1;
         cnt_ff         <= '0;
         walk_done_ff   <= 1'b0;
         s1_valid_ff    <= 1'b0;
         have_free_ff   <= 1'b0;
         head_ff        <= '0;
         last_active_ff <= '0;
         total_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (state_ff == ST_RESP && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         s1_valid_ff <= issue;
         if (issue) begin
            s1_idx_ff <= cnt_slot;
         end
         case (state_ff)
            ST_SWEEP: begin
               if (sweep_last) begin
                  cnt_ff   <= '0;
                  state_ff <= silent_ff ? ST_IDLE : ST_RESP;
               end else begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  op_ff        <= opcode_in;
                  idx_ok_ff    <= idx_ok;
                  tv_ok_ff     <= tv_ok;
                  silent_ff    <= 1'b0;
                  cnt_ff       <= '0;
                  walk_done_ff <= 1'b0;
                  case (opcode_in)
                     sflr_pkg::OP_CLEAR: begin
                        head_ff        <= '0;
                        last_active_ff <= '0;
                        total_ff       <= '0;
                        state_ff       <= ST_SWEEP;
                     end
                     sflr_pkg::OP_SET_LAST: begin
                        last_active_ff <= idx_ok ? idx_addr : AW'(NUM_SLOTS - 1);
                        state_ff       <= ST_RESP;
                     end
                     sflr_pkg::OP_REBUILD: begin
                        have_free_ff <= 1'b0;
                        last_used_ff <= '0;
                        state_ff     <= ST_RB_WALK;
                     end
                     sflr_pkg::OP_RECOUNT: begin
                        total_ff <= '0;
                        state_ff <= ST_RC_CLR;
                     end
                     default: begin
                        state_ff <= ST_RESP;
                     end
                  endcase
               end
            end
            ST_RB_WALK: begin
               if (issue) begin
                  if (rb_last) begin
                     walk_done_ff <= 1'b1;
                  end else begin
                     cnt_ff <= cnt_ff + CW'(1);
                  end
               end
               if (s1_valid_ff) begin
                  if (type_rd == '0) begin
                     if (!have_free_ff) begin
                        head_ff <= LW'(s1_idx_ff);
                     end
                     have_free_ff <= 1'b1;
                     last_free_ff <= s1_idx_ff;
                  end else begin
                     last_used_ff <= s1_idx_ff;
                  end
               end
               if (walk_done_ff && !s1_valid_ff) begin
                  state_ff <= ST_RB_END;
               end
            end
            ST_RB_END: begin
               if (!have_free_ff) begin
                  head_ff <= tail;
               end
               last_active_ff <= last_used_ff;
               state_ff       <= ST_RESP;
            end
            ST_RC_CLR: begin
               if (rc_clr_last) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_RC_WALK;
               end else begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            ST_RC_WALK: begin
               if (issue) begin
                  if (rc_walk_last) begin
                     walk_done_ff <= 1'b1;
                  end else begin
                     cnt_ff <= cnt_ff + CW'(1);
                  end
               end
               if (t_used) begin
                  total_ff <= total_ff + sflr_pkg::COUNT_W'(1);
               end
               if (walk_done_ff && !s1_valid_ff && !hist_busy) begin
                  state_ff <= ST_RESP;
               end
            end
            ST_RESP: begin
               if (out_free) begin
                  rsp_data_ff <= resp_data;
                  state_ff    <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_walk_stage_in_walk: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (state_ff == ST_RB_WALK || state_ff == ST_RC_WALK))
      else $error("slot read stage active outside a walk");

   a_inc_only_in_recount: assert property (@(posedge clock) disable iff (reset)
      hist_ctl.inc_en |-> (state_ff == ST_RC_WALK && !hist_ctl.clear_we))
      else $error("count increment outside recount walk");

   a_no_type_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      (slot_ctl.type_we || slot_ctl.clear_we)
         |-> !(state_ff == ST_RB_WALK || state_ff == ST_RC_WALK))
      else $error("slot type written during a walk");

   a_result_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("result loaded outside response state");
`endif

endmodule

// ===== design/sflr_slot_table.sv =====
// slot type and free-list link memories with registered read port
module sflr_slot_table #(
   parameter int NUM_SLOTS = 4096
) (
   input  logic                                   clock,
   input  sflr_pkg::slot_ctl_type                 ctl,
   input  logic [$clog2(NUM_SLOTS)-1:0]           rd_addr,
   input  logic [$clog2(NUM_SLOTS)-1:0]           wr_addr,
   input  logic [sflr_pkg::TYPE_W-1:0]            type_wr_data,
   input  logic signed [$clog2(NUM_SLOTS):0]      link_wr_data,
   output logic [sflr_pkg::TYPE_W-1:0]            type_rd_ff,
   output logic signed [$clog2(NUM_SLOTS):0]      link_rd_ff
);

   localparam int AW = $clog2(NUM_SLOTS);
   localparam int LW = AW + 1;

   logic [sflr_pkg::TYPE_W-1:0] type_mem [NUM_SLOTS];
   logic [LW-1:0]               link_mem [NUM_SLOTS];
   logic signed [LW-1:0]        clear_link;

   // cleared slot links to its successor, final slot ends the list
   assign clear_link = (wr_addr == AW'(NUM_SLOTS - 1)) ? '1 : LW'(wr_addr) + LW'(1);

   always_ff @(posedge clock) begin
      if (ctl.clear_we) begin
         type_mem[wr_addr] <= '0;
         link_mem[wr_addr] <= clear_link;
      end else begin
         if (ctl.type_we) begin
            type_mem[wr_addr] <= type_wr_data;
         end
         if (ctl.link_we) begin
            link_mem[wr_addr] <= link_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         type_rd_ff <= type_mem[rd_addr];
         link_rd_ff <= link_mem[rd_addr];
      end
   end

endmodule

// ===== design/sflr_hist.sv =====
// per-type count memory with read-modify-write increment and forwarding
module sflr_hist #(
   parameter int NUM_TYPES = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  sflr_pkg::hist_ctl_type             ctl,
   input  logic [$clog2(NUM_TYPES)-1:0]       addr,
   input  logic [$clog2(NUM_TYPES)-1:0]       inc_addr,
   output logic [sflr_pkg::COUNT_W-1:0]       rd_ff,
   output logic                               busy
);

   localparam int TW = $clog2(NUM_TYPES);

   logic [sflr_pkg::COUNT_W-1:0] count_mem [NUM_TYPES];
   logic [TW-1:0]                rd_addr;
   logic                         inc_valid_ff;
   logic [TW-1:0]                inc_addr_ff;
   logic                         fw_valid_ff;
   logic [TW-1:0]                fw_addr_ff;
   logic [sflr_pkg::COUNT_W-1:0] fw_data_ff;
   logic [sflr_pkg::COUNT_W-1:0] cur_count;
   logic [sflr_pkg::COUNT_W-1:0] sum_count;

   assign rd_addr   = ctl.inc_en ? inc_addr : addr;
   // write of the previous cycle is not yet in the read data
   assign cur_count = (fw_valid_ff && fw_addr_ff == inc_addr_ff) ? fw_data_ff : rd_ff;
   assign sum_count = cur_count + sflr_pkg::COUNT_W'(1);
   assign busy      = inc_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.clear_we) begin
         count_mem[addr] <= '0;
      end else if (inc_valid_ff) begin
         count_mem[inc_addr_ff] <= sum_count;
      end
      if (ctl.rd_en || ctl.inc_en) begin
         rd_ff <= count_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_valid_ff <= 1'b0;
         fw_valid_ff  <= 1'b0;
      end else begin
         inc_valid_ff <= ctl.inc_en;
         fw_valid_ff  <= inc_valid_ff && !ctl.clear_we;
      end
      inc_addr_ff <= inc_addr;
      fw_addr_ff  <= inc_addr_ff;
      fw_data_ff  <= sum_count;
   end

endmodule
